>>> src/asgr_pkg.sv
package asgr_pkg;

    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] OPEN_BYTE  = 8'h5B;
    localparam logic [7:0] CLOSE_BYTE = 8'h6D;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    localparam int unsigned CODE_W   = 10;
    localparam logic [CODE_W-1:0] CODE_MAX = 10'd1023;

    localparam logic [2:0] FG_DEFAULT = 3'd7;
    localparam logic [2:0] BG_DEFAULT = 3'd0;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_HELD   = 2'd1;
    localparam logic [1:0] MODE_SEQ    = 2'd2;

    localparam logic KIND_TEXT  = 1'b0;
    localparam logic KIND_COLOR = 1'b1;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned COUNT_W     = 3;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [2:0] fg_color;
        logic [2:0] bg_color;
        logic       last;
    } result_t;

endpackage

>>> src/ansi_sgr_color_filter.sv
// Splits a byte stream into text results and colour-change results. ESC '[' opens an
// SGR sequence, decimal digits build one code (saturating at 1023) and 'm' closes it
// with one colour result carrying the updated foreground and background. A byte is
// taken every cycle while the four-entry result queue has at least two free places;
// results enter the queue as their byte is taken and leave it one per cycle while
// res_ready is high. A held ESC then any byte but '[' gives two results (one if it
// is an ESC held again), but the held ESC gave none, so with res_ready high the input
// keeps one byte per cycle; only result stalls fill the queue and drop text_ready.
module ansi_sgr_color_filter
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_ready,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       kind,
    output logic [7:0] out_byte,
    output logic [2:0] fg_color,
    output logic [2:0] bg_color,
    output logic       last
);

    logic [1:0]                       mode_reg, mode_next;
    logic [asgr_pkg::CODE_W-1:0]      code_reg, code_next;
    logic [2:0]                       fg_reg, fg_next;
    logic [2:0]                       bg_reg, bg_next;
    logic [asgr_pkg::COUNT_W-1:0]     count_reg, count_next;
    asgr_pkg::result_t                queue_reg [asgr_pkg::QUEUE_DEPTH];
    asgr_pkg::result_t                queue_next [asgr_pkg::QUEUE_DEPTH];

    logic                             take;
    logic                             pop;
    logic [1:0]                       n_res;
    asgr_pkg::result_t                res0, res1;
    logic                             is_digit;
    logic [13:0]                      code_acc;
    logic [asgr_pkg::CODE_W-1:0]      code_sat;
    logic [asgr_pkg::CODE_W-1:0]      sub30, sub90, sub40, sub100;
    logic [2:0]                       fg_close, bg_close;
    logic [asgr_pkg::COUNT_W-1:0]     base;

    assign text_ready = (count_reg <= asgr_pkg::COUNT_W'(asgr_pkg::QUEUE_DEPTH - 2));
    assign res_valid  = (count_reg != '0);
    assign take       = text_valid && text_ready;
    assign pop        = res_valid && res_ready;

    assign kind     = queue_reg[0].kind;
    assign out_byte = queue_reg[0].out_byte;
    assign fg_color = queue_reg[0].fg_color;
    assign bg_color = queue_reg[0].bg_color;
    assign last     = queue_reg[0].last;

    // code * 10 + digit
    assign is_digit = (text_byte >= asgr_pkg::DIGIT_ZERO) && (text_byte <= asgr_pkg::DIGIT_NINE);
    assign code_acc = {1'b0, code_reg, 3'b000} + {3'b000, code_reg, 1'b0}
                    + {10'd0, 4'(text_byte - asgr_pkg::DIGIT_ZERO)};
    assign code_sat = (code_acc > 14'(asgr_pkg::CODE_MAX)) ? asgr_pkg::CODE_MAX
                                                           : code_acc[asgr_pkg::CODE_W-1:0];

    assign sub30  = code_reg - 10'd30;
    assign sub90  = code_reg - 10'd90;
    assign sub40  = code_reg - 10'd40;
    assign sub100 = code_reg - 10'd100;

    // colour update on close
    always_comb
    begin
        fg_close = fg_reg;
        bg_close = bg_reg;
        if (code_reg == '0)
        begin
            fg_close = asgr_pkg::FG_DEFAULT;
            bg_close = asgr_pkg::BG_DEFAULT;
        end
        else if (code_reg inside {[10'd30:10'd37]})
        begin
            fg_close = sub30[2:0];
        end
        else if (code_reg inside {[10'd90:10'd97]})
        begin
            fg_close = sub90[2:0];
        end
        else if (code_reg inside {[10'd40:10'd47]})
        begin
            bg_close = sub40[2:0];
        end
        else if (code_reg inside {[10'd100:10'd107]})
        begin
            bg_close = sub100[2:0];
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        code_next = code_reg;
        fg_next   = fg_reg;
        bg_next   = bg_reg;
        n_res     = 2'd0;
        res0      = '{kind: asgr_pkg::KIND_TEXT, out_byte: text_byte,
                      fg_color: fg_reg, bg_color: bg_reg, last: 1'b1};
        res1      = res0;
        if (take)
        begin
            case (mode_reg)
                asgr_pkg::MODE_HELD:
                begin
                    if (text_byte == asgr_pkg::OPEN_BYTE)
                    begin
                        code_next = '0;
                        mode_next = end_of_text ? asgr_pkg::MODE_NORMAL : asgr_pkg::MODE_SEQ;
                    end
                    else
                    begin
                        res0.out_byte = asgr_pkg::ESC_BYTE;
                        if (text_byte == asgr_pkg::ESC_BYTE && !end_of_text)
                        begin
                            mode_next = asgr_pkg::MODE_HELD;
                            n_res     = 2'd1;
                        end
                        else
                        begin
                            // held escape goes out first, then this byte
                            res0.last = 1'b0;
                            mode_next = asgr_pkg::MODE_NORMAL;
                            n_res     = 2'd2;
                        end
                    end
                end
                asgr_pkg::MODE_SEQ:
                begin
                    if (text_byte == asgr_pkg::CLOSE_BYTE)
                    begin
                        fg_next       = fg_close;
                        bg_next       = bg_close;
                        code_next     = '0;
                        mode_next     = asgr_pkg::MODE_NORMAL;
                        res0.kind     = asgr_pkg::KIND_COLOR;
                        res0.out_byte = 8'd0;
                        res0.fg_color = fg_close;
                        res0.bg_color = bg_close;
                        n_res         = 2'd1;
                    end
                    else
                    begin
                        if (is_digit)
                        begin
                            code_next = code_sat;
                        end
                        if (end_of_text)
                        begin
                            code_next = '0;
                            mode_next = asgr_pkg::MODE_NORMAL;
                        end
                    end
                end
                default:
                begin
                    if (text_byte == asgr_pkg::ESC_BYTE && !end_of_text)
                    begin
                        mode_next = asgr_pkg::MODE_HELD;
                    end
                    else
                    begin
                        mode_next = asgr_pkg::MODE_NORMAL;
                        n_res     = 2'd1;
                    end
                end
            endcase
        end
    end

    // result queue: shift on pop, append up to two entries
    assign base       = count_reg - asgr_pkg::COUNT_W'(pop);
    assign count_next = base + asgr_pkg::COUNT_W'(n_res);

    always_comb
    begin
        for (int i = 0; i < asgr_pkg::QUEUE_DEPTH; i++)
        begin
            if (pop && (i < asgr_pkg::QUEUE_DEPTH - 1))
            begin
                queue_next[i] = queue_reg[i+1];
            end
            else
            begin
                queue_next[i] = queue_reg[i];
            end
            if (n_res != 2'd0 && asgr_pkg::COUNT_W'(i) == base)
            begin
                queue_next[i] = res0;
            end
            if (n_res == 2'd2 && asgr_pkg::COUNT_W'(i) == base + 3'd1)
            begin
                queue_next[i] = res1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= asgr_pkg::MODE_NORMAL;
            code_reg  <= '0;
            fg_reg    <= asgr_pkg::FG_DEFAULT;
            bg_reg    <= asgr_pkg::BG_DEFAULT;
            count_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            code_reg  <= code_next;
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < asgr_pkg::QUEUE_DEPTH; i++)
        begin
            queue_reg[i] <= queue_next[i];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= asgr_pkg::COUNT_W'(asgr_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_code_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != asgr_pkg::MODE_SEQ |-> code_reg == '0)
        else $error("code not cleared outside a sequence");

    a_reset_code: assert property (@(posedge clk) disable iff (!rst_n)
        take && mode_reg == asgr_pkg::MODE_SEQ && text_byte == asgr_pkg::CLOSE_BYTE
        && code_reg == '0
        |=> fg_reg == asgr_pkg::FG_DEFAULT && bg_reg == asgr_pkg::BG_DEFAULT)
        else $error("code zero did not restore default colours");

    a_held_two: assert property (@(posedge clk) disable iff (!rst_n)
        take && !pop && mode_reg == asgr_pkg::MODE_HELD && text_byte != asgr_pkg::OPEN_BYTE
        && (text_byte != asgr_pkg::ESC_BYTE || end_of_text)
        |=> count_reg == $past(count_reg) + 3'd2)
        else $error("held escape did not queue two results");

endmodule

>>> test/tb_top.sv
module tb_top;

    // one text request and, for the hand-checked rows, the results it must give
    typedef struct {
        logic [7:0]        b;
        logic              eot;
        int                n_typed;
        asgr_pkg::result_t e0;
        asgr_pkg::result_t e1;
    } text_req_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       text_valid = 1'b0;
    logic       text_ready;
    logic [7:0] text_byte = 8'h00;
    logic       end_of_text = 1'b0;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic       kind;
    logic [7:0] out_byte;
    logic [2:0] fg_color;
    logic [2:0] bg_color;
    logic       last;

    // shadow copy of the parser state
    logic [1:0]                  sgr_mode = asgr_pkg::MODE_NORMAL;
    logic [asgr_pkg::CODE_W-1:0] sgr_code = '0;
    logic [2:0]                  cur_fg = asgr_pkg::FG_DEFAULT;
    logic [2:0]                  cur_bg = asgr_pkg::BG_DEFAULT;

    text_req_t         stim_q[$];
    asgr_pkg::result_t pending_results[$];
    int                fault_count = 0;

    ansi_sgr_color_filter uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .kind        (kind),
        .out_byte    (out_byte),
        .fg_color    (fg_color),
        .bg_color    (bg_color),
        .last        (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic eot, input int n = -1,
                           input asgr_pkg::result_t e0 = '0,
                           input asgr_pkg::result_t e1 = '0);
        text_req_t r;
        r.b = b;
        r.eot = eot;
        r.n_typed = n;
        r.e0 = e0;
        r.e1 = e1;
        stim_q.push_back(r);
    endtask

    // advances the shadow state by one byte and returns the results it causes
    task automatic predict_sgr(input logic [7:0] b, input logic eot, output int n,
                               output asgr_pkg::result_t r0,
                               output asgr_pkg::result_t r1);
        asgr_pkg::result_t r[2];
        logic              plain;
        int                v;
        int                c;
        n = 0;
        plain = 1'b0;
        r[0] = '0;
        r[1] = '0;
        case (sgr_mode)
            asgr_pkg::MODE_HELD:
            begin
                if (b == asgr_pkg::OPEN_BYTE)
                begin
                    sgr_code = '0;
                    sgr_mode = eot ? asgr_pkg::MODE_NORMAL : asgr_pkg::MODE_SEQ;
                end
                else
                begin
                    r[n] = '{asgr_pkg::KIND_TEXT, asgr_pkg::ESC_BYTE, cur_fg, cur_bg, 1'b0};
                    n++;
                    plain = 1'b1;
                end
            end
            asgr_pkg::MODE_SEQ:
            begin
                if (b == asgr_pkg::CLOSE_BYTE)
                begin
                    c = int'(sgr_code);
                    if (c == 0)
                    begin
                        cur_fg = asgr_pkg::FG_DEFAULT;
                        cur_bg = asgr_pkg::BG_DEFAULT;
                    end
                    else if (c >= 30 && c <= 37)
                        cur_fg = 3'(c - 30);
                    else if (c >= 90 && c <= 97)
                        cur_fg = 3'(c - 90);
                    else if (c >= 40 && c <= 47)
                        cur_bg = 3'(c - 40);
                    else if (c >= 100 && c <= 107)
                        cur_bg = 3'(c - 100);
                    sgr_code = '0;
                    sgr_mode = asgr_pkg::MODE_NORMAL;
                    r[n] = '{asgr_pkg::KIND_COLOR, 8'h00, cur_fg, cur_bg, 1'b0};
                    n++;
                end
                else
                begin
                    if (b >= asgr_pkg::DIGIT_ZERO && b <= asgr_pkg::DIGIT_NINE)
                    begin
                        v = int'(sgr_code) * 10 + int'(b - asgr_pkg::DIGIT_ZERO);
                        sgr_code = (v > int'(asgr_pkg::CODE_MAX)) ? asgr_pkg::CODE_MAX
                                                                  : asgr_pkg::CODE_W'(v);
                    end
                    if (eot)
                    begin
                        sgr_code = '0;
                        sgr_mode = asgr_pkg::MODE_NORMAL;
                    end
                end
            end
            default:
                plain = 1'b1;
        endcase
        if (plain)
        begin
            if (b == asgr_pkg::ESC_BYTE && !eot)
                sgr_mode = asgr_pkg::MODE_HELD;
            else
            begin
                sgr_mode = asgr_pkg::MODE_NORMAL;
                r[n] = '{asgr_pkg::KIND_TEXT, b, cur_fg, cur_bg, 1'b0};
                n++;
            end
        end
        if (n > 0)
            r[n-1].last = 1'b1;
        r0 = r[0];
        r1 = r[1];
    endtask

    function automatic logic [7:0] junk_byte();
        logic [7:0] j;
        do
            j = 8'($urandom_range(0, 255));
        while ((j >= asgr_pkg::DIGIT_ZERO && j <= asgr_pkg::DIGIT_NINE)
               || j == asgr_pkg::CLOSE_BYTE);
        return j;
    endfunction

    task automatic add_code_digits(input int code, input logic end_on_last);
        string s;
        int    i;
        s = $sformatf("%0d", code);
        for (i = 0; i < s.len(); i++)
        begin
            if ($urandom_range(0, 9) == 0)
                add_row(junk_byte(), 1'b0);
            add_row(s[i], end_on_last && (i == s.len() - 1));
        end
    endtask

    task automatic build_random_text(input int count);
        int target;
        int sel;
        int code;
        int k;
        target = stim_q.size() + count;
        while (stim_q.size() < target)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 35)
                add_row(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            else if (sel < 75)
            begin
                // well-formed colour sequence with random content
                add_row(asgr_pkg::ESC_BYTE, 1'b0);
                add_row(asgr_pkg::OPEN_BYTE, 1'b0);
                case ($urandom_range(0, 5))
                    0: code = 0;
                    1: code = 30 + $urandom_range(0, 7);
                    2: code = 90 + $urandom_range(0, 7);
                    3: code = 40 + $urandom_range(0, 7);
                    4: code = 100 + $urandom_range(0, 7);
                    default: code = $urandom_range(0, 1023);
                endcase
                if ($urandom_range(0, 3) == 0)
                    add_row(asgr_pkg::DIGIT_ZERO, 1'b0);
                if ($urandom_range(0, 7) == 0)
                begin
                    // long digit run that can drive the code into saturation
                    for (k = 0; k < 3 + $urandom_range(0, 3); k++)
                        add_row(asgr_pkg::DIGIT_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                end
                else if ($urandom_range(0, 5) != 0)
                    add_code_digits(code, 1'b0);
                if ($urandom_range(0, 7) == 0)
                    add_row(junk_byte(), 1'b0);
                add_row(asgr_pkg::CLOSE_BYTE, $urandom_range(0, 5) == 0);
            end
            else if (sel < 87)
            begin
                add_row(asgr_pkg::ESC_BYTE, 1'b0);
                add_row(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
            end
            else
            begin
                // broken sequences cut off by end of text
                case ($urandom_range(0, 3))
                    0: add_row(asgr_pkg::ESC_BYTE, 1'b1);
                    1:
                    begin
                        add_row(asgr_pkg::ESC_BYTE, 1'b0);
                        add_row(asgr_pkg::OPEN_BYTE, 1'b1);
                    end
                    2:
                    begin
                        add_row(asgr_pkg::ESC_BYTE, 1'b0);
                        add_row(asgr_pkg::OPEN_BYTE, 1'b0);
                        add_code_digits($urandom_range(0, 200), 1'b1);
                    end
                    default:
                    begin
                        add_row(asgr_pkg::ESC_BYTE, 1'b0);
                        add_row(asgr_pkg::OPEN_BYTE, 1'b0);
                        add_row(junk_byte(), 1'b1);
                    end
                endcase
            end
        end
    endtask

    // receiver stalls follow a pattern that changes after each random stretch
    initial
    begin
        int pattern;
        int stretch;
        int cyc;
        pattern = 0;
        stretch = 0;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (stretch == 0)
            begin
                pattern = $urandom_range(0, 3);
                stretch = $urandom_range(16, 80);
            end
            stretch--;
            case (pattern)
                0: res_ready <= 1'b1;
                1: res_ready <= 1'($urandom_range(0, 1));
                2: res_ready <= (cyc % 4) != 0;
                default: res_ready <= $urandom_range(0, 5) == 0;
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        asgr_pkg::result_t got;
        asgr_pkg::result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            got = '{kind, out_byte, fg_color, bg_color, last};
            if (pending_results.size() == 0)
                note_fault($sformatf(
                    "unexpected result kind=%0d byte=%02h fg=%0d bg=%0d last=%0d",
                    got.kind, got.out_byte, got.fg_color, got.bg_color, got.last));
            else
            begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                    got.fg_color !== want.fg_color || got.bg_color !== want.bg_color ||
                    got.last !== want.last)
                    note_fault($sformatf({"mismatch: expected kind=%0d byte=%02h fg=%0d ",
                                          "bg=%0d last=%0d, got kind=%0d byte=%02h ",
                                          "fg=%0d bg=%0d last=%0d"},
                        want.kind, want.out_byte, want.fg_color, want.bg_color, want.last,
                        got.kind, got.out_byte, got.fg_color, got.bg_color, got.last));
            end
        end
    end

    initial
    begin
        int                idx;
        int                gap;
        int                burst_left;
        int                n;
        int                directed_end;
        int                mid_pause;
        asgr_pkg::result_t r0;
        asgr_pkg::result_t r1;

        // plain text after reset and byte extremes
        add_row(8'h41, 1'b0, 1, asgr_pkg::result_t'{asgr_pkg::KIND_TEXT, 8'h41,
                asgr_pkg::FG_DEFAULT, asgr_pkg::BG_DEFAULT, 1'b1});
        add_row(8'h00, 1'b0, 1, asgr_pkg::result_t'{asgr_pkg::KIND_TEXT, 8'h00,
                asgr_pkg::FG_DEFAULT, asgr_pkg::BG_DEFAULT, 1'b1});
        add_row(8'hFF, 1'b1, 1, asgr_pkg::result_t'{asgr_pkg::KIND_TEXT, 8'hFF,
                asgr_pkg::FG_DEFAULT, asgr_pkg::BG_DEFAULT, 1'b1});
        // held escape released by an ordinary byte
        add_row(asgr_pkg::ESC_BYTE, 1'b0, 0);
        add_row(8'h78, 1'b0, 2,
                asgr_pkg::result_t'{asgr_pkg::KIND_TEXT, asgr_pkg::ESC_BYTE,
                                    asgr_pkg::FG_DEFAULT, asgr_pkg::BG_DEFAULT, 1'b0},
                asgr_pkg::result_t'{asgr_pkg::KIND_TEXT, 8'h78,
                                    asgr_pkg::FG_DEFAULT, asgr_pkg::BG_DEFAULT, 1'b1});
        // escape on the final byte goes straight out
        add_row(asgr_pkg::ESC_BYTE, 1'b1, 1,
                asgr_pkg::result_t'{asgr_pkg::KIND_TEXT, asgr_pkg::ESC_BYTE,
                                    asgr_pkg::FG_DEFAULT, asgr_pkg::BG_DEFAULT, 1'b1});
        // escape then escape, then a bright foreground
        add_row(asgr_pkg::ESC_BYTE, 1'b0);
        add_row(asgr_pkg::ESC_BYTE, 1'b0);
        add_row(asgr_pkg::OPEN_BYTE, 1'b0);
        add_row(asgr_pkg::DIGIT_ZERO + 8'd9, 1'b0);
        add_row(asgr_pkg::DIGIT_ZERO + 8'd7, 1'b0);
        add_row(asgr_pkg::CLOSE_BYTE, 1'b0);
        // top bright background with an escape ignored inside
        add_row(asgr_pkg::ESC_BYTE, 1'b0);
        add_row(asgr_pkg::OPEN_BYTE, 1'b0);
        add_row(asgr_pkg::DIGIT_ZERO + 8'd1, 1'b0);
        add_row(asgr_pkg::DIGIT_ZERO, 1'b0);
        add_row(asgr_pkg::DIGIT_ZERO + 8'd7, 1'b0);
        add_row(asgr_pkg::ESC_BYTE, 1'b0);
        add_row(asgr_pkg::CLOSE_BYTE, 1'b0);
        // open on the final byte, then a sequence cut off mid-code
        add_row(asgr_pkg::ESC_BYTE, 1'b0);
        add_row(asgr_pkg::OPEN_BYTE, 1'b1);
        add_row(asgr_pkg::ESC_BYTE, 1'b0);
        add_row(asgr_pkg::OPEN_BYTE, 1'b0);
        add_row(asgr_pkg::DIGIT_ZERO + 8'd5, 1'b1);
        // empty code restores the defaults
        add_row(asgr_pkg::ESC_BYTE, 1'b0);
        add_row(asgr_pkg::OPEN_BYTE, 1'b0);
        add_row(asgr_pkg::CLOSE_BYTE, 1'b0);
        directed_end = stim_q.size();
        build_random_text(620);
        mid_pause = directed_end + (stim_q.size() - directed_end) / 2;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = 0;
        for (idx = 0; idx < stim_q.size(); idx++)
        begin
            if (idx == directed_end || idx == mid_pause)
            begin
                text_valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    text_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            text_valid <= 1'b1;
            text_byte <= stim_q[idx].b;
            end_of_text <= stim_q[idx].eot;
            do
                @(posedge clk);
            while (!text_ready);
            predict_sgr(stim_q[idx].b, stim_q[idx].eot, n, r0, r1);
            if (stim_q[idx].n_typed >= 0)
            begin
                n = stim_q[idx].n_typed;
                r0 = stim_q[idx].e0;
                r1 = stim_q[idx].e1;
            end
            if (n > 0)
                pending_results.push_back(r0);
            if (n > 1)
                pending_results.push_back(r1);
        end
        text_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fault_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
